// File: design/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants for the sorting engine: word width and the link
// record passed between neighboring cells of the sort chain.
// ----------------------------------------------------------------------------
package qse_pkg;

	// element width on both stream sides
	localparam int DATA_W = 32;

	// state one cell exposes to its neighbors
	typedef struct packed {
		logic                     valid;  // cell holds an element
		logic signed [DATA_W-1:0] value;  // held element
		logic                     gt;     // empty or holds a value above the incoming word
	} link_t;

endpackage

// File: design/qse_cell.sv
// ----------------------------------------------------------------------------
// qse_cell
// One slot of the sort chain. Keeps one element; on insert it either keeps
// its element, takes the incoming word, or takes its lower neighbor's element
// (shift up). On pop it takes its upper neighbor's element (shift down).
// ----------------------------------------------------------------------------
module qse_cell
	import qse_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ins,   // insert word x this cycle
	input  logic                     pop,   // shift chain toward cell 0
	input  logic signed [DATA_W-1:0] x,
	input  link_t                    prev,  // neighbor toward the head
	input  link_t                    next,  // neighbor toward the tail
	output link_t                    own
);

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     gt;

	// empty slots order as plus infinity
	always_comb begin
		gt = !valid_q || (value_q > x);
		own.valid = valid_q;
		own.value = value_q;
		own.gt    = gt;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			if (prev.gt) begin
				valid_q <= prev.valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (pop) begin
			valid_q <= next.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ins) begin
			if (prev.gt) begin
				value_q <= prev.value;
			end else if (gt) begin
				value_q <= x;
			end
		end else if (pop) begin
			value_q <= next.value;
		end
	end

endmodule

// File: design/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects a set of signed words and returns them in ascending order.
// The first sorted word is offered in the cycle after the last input is taken.
// Words load as the source offers them and leave as the receiver takes them;
//   input is held off while a set drains.
// Ordering is done on insert by the chain of DEPTH compare-and-shift cells.
// Reset (arst_n low) empties the chain and clears count and overflow.
// ----------------------------------------------------------------------------
module quicksort_engine
	import qse_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,   // last
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,   // final_res
	output logic              m_tuser    // [0] overflow
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	logic in_acc, out_acc, ins, not_full;
	link_t links [DEPTH];
	link_t head_link, tail_link;

	assign not_full = count_q < CNT_W'(DEPTH);
	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign ins      = in_acc && not_full;
	assign m_tvalid = (state_q == ST_EMIT);
	assign out_acc  = m_tvalid && m_tready;

	assign m_tdata = links[0].value;
	assign m_tlast = (count_q == CNT_W'(1));
	assign m_tuser = overflow_q;

	// boundary links: nothing above the head, an empty slot past the tail
	assign head_link = '{valid: 1'b0, value: '0, gt: 1'b0};
	assign tail_link = '{valid: 1'b0, value: '0, gt: 1'b1};

	// sort chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		link_t prev_l, next_l;
		if (i == 0) begin : g_head
			assign prev_l = head_link;
		end else begin : g_mid_p
			assign prev_l = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_l = tail_link;
		end else begin : g_mid_n
			assign next_l = links[i+1];
		end
		qse_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ins    (ins),
			.pop    (out_acc),
			.x      (s_tdata),
			.prev   (prev_l),
			.next   (next_l),
			.own    (links[i])
		);
	end

	// load / drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (not_full) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q    <= ST_LOAD;
							overflow_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// File: test/quicksort_engine_tb.sv
// ----------------------------------------------------------------------------
// quicksort_engine_tb
// Loads sets of signed words into the sorting engine and checks every sorted
// word it returns against an ascending sort computed in the bench. Covers
// single-word sets, duplicates, extreme values and a set that fills the store
// and then overflows it. Both stream sides idle at random, and the receiver
// holds off for one long stretch to back the engine up.
// ----------------------------------------------------------------------------
module quicksort_engine_tb
	import qse_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_DEPTH   = 64;
	localparam int SMALL_ITEMS = 10;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_WAIT  = 20;

	localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	// one expected output word
	typedef struct {
		logic [DATA_W-1:0] value;
		logic              fin;
		logic              ovf;
	} sorted_word_t;

	// tracks the set being loaded and the sorted words still owed
	class sort_scoreboard;
		logic signed [DATA_W-1:0] set_vals[$];
		bit                       set_ovf;
		sorted_word_t             owed[$];
		int                       n_in;
		int                       n_sets;
		int                       n_checked;
		int                       n_errors;

		function void note_input(logic [DATA_W-1:0] v, logic l);
			logic signed [DATA_W-1:0] key;
			sorted_word_t             w;
			int                       i;
			int                       j;
			n_in++;
			if (set_vals.size() < SET_DEPTH)
				set_vals.push_back(v);
			else
				set_ovf = 1'b1;
			if (!l)
				return;
			// ascending order, duplicates kept
			for (i = 1; i < set_vals.size(); i++) begin
				key = set_vals[i];
				j = i - 1;
				while (j >= 0 && set_vals[j] > key) begin
					set_vals[j+1] = set_vals[j];
					j--;
				end
				set_vals[j+1] = key;
			end
			for (i = 0; i < set_vals.size(); i++) begin
				w.value = set_vals[i];
				w.fin   = (i == set_vals.size() - 1);
				w.ovf   = set_ovf;
				owed.push_back(w);
			end
			set_vals.delete();
			set_ovf = 1'b0;
			n_sets++;
		endfunction

		function void check_word(logic [DATA_W-1:0] d, logic l, logic u);
			sorted_word_t w;
			if (owed.size() == 0) begin
				$error("unexpected sorted word %h", d);
				n_errors++;
				return;
			end
			w = owed.pop_front();
			n_checked++;
			if (d !== w.value) begin
				$error("sorted_value expected %0d got %0d",
					$signed(w.value), $signed(d));
				n_errors++;
			end
			if (l !== w.fin) begin
				$error("final_res expected %b got %b", w.fin, l);
				n_errors++;
			end
			if (u !== w.ovf) begin
				$error("overflow expected %b got %b", w.ovf, u);
				n_errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	sort_scoreboard sb = new();
	bit             calm;
	int             idle_cycles;

	quicksort_engine #(.DEPTH(SET_DEPTH)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// offer one word, idling at random first, and wait until it is taken
	task automatic send_word(input logic [DATA_W-1:0] v, input logic l);
		while (!calm && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(v, l);
	endtask

	task automatic send_set(input logic [DATA_W-1:0] vals[$]);
		foreach (vals[i])
			send_word(vals[i], i == vals.size() - 1);
	endtask

	// mix of full-range, clustered (duplicates) and extreme values
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(7) - 4;
			1: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return VAL_NEG1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// set of n random words, last marked on the final one
	task automatic send_random_set(input int n);
		for (int i = 0; i < n; i++)
			send_word(pick_value(), i == n - 1);
	endtask

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int hold;
		bit hold_done;
		bit ready;
		hold = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold > 0) begin
				ready = 1'b0;
				hold--;
			end else if (!hold_done && sb.n_checked >= 30) begin
				hold_done = 1'b1;
				hold = HOLD_CYCLES - 1;
				ready = 1'b0;
			end else begin
				ready = calm || $urandom_range(99) >= 32;
			end
			m_tready <= ready;
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tlast, m_tuser);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no word moved", idle_cycles);
			$display("FAIL quicksort_engine");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [DATA_W-1:0] vals[$];
		int                small_items;
		int                n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		calm = 1'b0;
		idle_cycles = 0;
		small_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single words at both extremes, then a two-word set
		vals = '{VAL_MIN};
		send_set(vals);
		vals = '{VAL_MAX};
		send_set(vals);
		vals = '{32'd5, -32'sd3};
		send_set(vals);
		// extremes mixed together
		vals = '{VAL_MAX, VAL_MIN, 32'd0, VAL_NEG1, 32'd1, 32'h7FFF_FFFE, 32'h8000_0001};
		send_set(vals);
		// duplicates
		vals = '{32'd3, 32'd3, VAL_NEG1, 32'd3, VAL_NEG1, 32'd0};
		send_set(vals);
		// already ascending, then descending
		vals = '{32'd1, 32'd2, 32'd3, 32'd4};
		send_set(vals);
		vals = '{32'd4, 32'd3, 32'd2, 32'd1};
		send_set(vals);

		// random sets, mostly small
		while (small_items < SMALL_ITEMS) begin
			n = ($urandom_range(9) == 0) ? 1 : $urandom_range(10, 2);
			send_random_set(n);
			small_items += n;
		end

		// fill the store and overflow it, last two words dropped; no idling here
		calm = 1'b1;
		send_random_set(SET_DEPTH + 2);
		s_tvalid <= 1'b0;

		while (sb.owed.size() > 0)
			@(posedge clk);
		calm = 1'b0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.owed.size() != 0 || sb.set_vals.size() != 0) begin
			$error("%0d sorted words never arrived", sb.owed.size());
			sb.n_errors++;
		end

		$display("Sorted %0d sets from %0d input words, %0d output words checked,",
			sb.n_sets, sb.n_in, sb.n_checked);
		$display("including single-word sets and one set that filled and overflowed the store.");
		if (sb.n_errors == 0)
			$display("PASS quicksort_engine");
		else
			$display("FAIL quicksort_engine");
		$finish;
	end

endmodule

// File: filelist.f
design/qse_pkg.sv
design/qse_cell.sv
design/quicksort_engine.sv
test/quicksort_engine_tb.sv
